>>> rtl/core/hsa_pkg.sv
// types, codes and a helper function shared by the handle slot allocator
package hsa_pkg;

	localparam int GROUP = 8;
	localparam int GSW   = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_FULL        = 3'd1,
		STS_EMPTY       = 3'd2,
		STS_MISMATCH    = 3'd3,
		STS_BAD_INDEX   = 3'd4,
		STS_FREE_REMOVE = 3'd5
	} status_t;

	localparam logic [1:0] REG_START_ID = 2'd0;

	// lowest clear bit of a group: {found, position}
	function automatic logic [GSW:0] first_free(input logic [GROUP-1:0] bits);
		logic [GSW:0] r;
		r = '0;
		for (int i = GROUP - 1; i >= 0; i--) begin
			if (!bits[i]) begin
				r = {1'b1, GSW'(i)};
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/handle_slot_allocator.sv
// handle slot allocator: occupancy scan, id store and generation id counter
// a word is taken in idle, then exec decides remove and lookup directly or scans for insert
// in groups of eight slots, up to ceil(SLOTS/8) groups; the result is valid the cycle after
// the result waits in an output register and idle takes the next word;
// a waiting result holds exec
// reset clears occupancy, count, high water and the id counter at once; no clearing pass
module handle_slot_allocator #(
	parameter int SLOTS             = 64,
	parameter int unsigned ID_LIMIT = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [5:0]  slot_index,
	input  logic [15:0] check_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  result_slot,
	output logic [15:0] result_id,
	output logic [6:0]  live_count,
	output logic [5:0]  high_water
);

	localparam int AW   = (SLOTS > 2) ? $clog2(SLOTS) : 1;
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int NGRP = (SLOTS + hsa_pkg::GROUP - 1) / hsa_pkg::GROUP;
	localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int PW   = NGRP * hsa_pkg::GROUP;

	hsa_pkg::state_t state_q, state_d;

	logic [15:0]      start_id_q;
	logic [15:0]      id_counter_q;
	logic [SLOTS-1:0] occ_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    max_slot_q;
	logic [GW-1:0]    grp_q;
	logic [1:0]       kind_q;
	logic [5:0]       slot_index_q;
	logic [15:0]      check_id_q;
	logic [15:0]      slot_id_q [SLOTS];
	logic [15:0]      rd_q;
	logic [2:0]       status_q;
	logic [5:0]       result_slot_q;
	logic [15:0]      result_id_q;
	logic             out_valid_q;

	logic              cfg_wr;
	logic              in_acc;
	logic              out_free;
	logic [15:0]       id_adv;
	logic [31:0]       idx_ext;
	logic [31:0]       rd_ext;
	logic [AW-1:0]     idx_addr;
	logic [AW-1:0]     rd_addr;
	logic              in_range;
	logic [PW-1:0]     occ_pad;
	logic [hsa_pkg::GROUP-1:0] grp_bits;
	logic [hsa_pkg::GSW:0]     fs;
	logic [31:0]       slot_ext;
	logic [AW-1:0]     ins_slot;
	logic              last_grp;
	logic              exec_done;
	logic              wr_en;
	logic              occ_set;
	logic              occ_clr;
	logic              grp_inc;
	logic [2:0]        r_status;
	logic [5:0]        r_slot;
	logic [15:0]       r_id;
	logic [31:0]       count_ext;
	logic [31:0]       max_ext;

	assign pready = 1'b1;
	assign prdata = {16'b0, start_id_q};
	assign cfg_wr = psel & penable & pwrite & pready & (paddr == hsa_pkg::REG_START_ID);

	assign in_stall = (state_q != hsa_pkg::ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	assign id_adv = ({16'b0, id_counter_q} >= 32'(ID_LIMIT)) ? 16'd1 : id_counter_q + 16'd1;

	assign idx_ext  = {26'b0, slot_index_q};
	assign idx_addr = idx_ext[AW-1:0];
	assign in_range = idx_ext < 32'(SLOTS);
	assign rd_ext   = {26'b0, slot_index};
	assign rd_addr  = rd_ext[AW-1:0];

	always_comb begin
		occ_pad = '1;
		occ_pad[SLOTS-1:0] = occ_q;
	end

	assign grp_bits = occ_pad[32'(grp_q) * hsa_pkg::GROUP +: hsa_pkg::GROUP];
	assign fs       = hsa_pkg::first_free(grp_bits);
	assign slot_ext = 32'({grp_q, fs[hsa_pkg::GSW-1:0]});
	assign ins_slot = slot_ext[AW-1:0];
	assign last_grp = (grp_q == GW'(NGRP - 1));

	assign count_ext  = 32'(count_q);
	assign max_ext    = 32'(max_slot_q);
	assign live_count = count_ext[6:0];
	assign high_water = max_ext[5:0];

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_slot = result_slot_q;
	assign result_id   = result_id_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hsa_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = hsa_pkg::ST_EXEC;
				end
			end
			hsa_pkg::ST_EXEC: begin
				if (exec_done) begin
					state_d = hsa_pkg::ST_IDLE;
				end
			end
			default: state_d = hsa_pkg::ST_IDLE;
		endcase
	end

	// work of the exec step
	always_comb begin
		exec_done = 1'b0;
		wr_en     = 1'b0;
		occ_set   = 1'b0;
		occ_clr   = 1'b0;
		grp_inc   = 1'b0;
		r_status  = hsa_pkg::STS_BAD_INDEX;
		r_slot    = slot_index_q;
		r_id      = 16'd0;
		if (state_q == hsa_pkg::ST_EXEC && out_free) begin
			unique case (kind_q)
				hsa_pkg::KIND_INSERT: begin
					if (fs[hsa_pkg::GSW]) begin
						exec_done = 1'b1;
						wr_en     = 1'b1;
						occ_set   = 1'b1;
						r_status  = hsa_pkg::STS_OK;
						r_slot    = slot_ext[5:0];
						r_id      = id_counter_q;
					end else if (last_grp) begin
						exec_done = 1'b1;
						r_status  = hsa_pkg::STS_FULL;
						r_slot    = 6'd0;
					end else begin
						grp_inc = 1'b1;
					end
				end
				hsa_pkg::KIND_REMOVE: begin
					exec_done = 1'b1;
					if (!in_range) begin
						r_status = hsa_pkg::STS_BAD_INDEX;
					end else if (!occ_q[idx_addr]) begin
						r_status = hsa_pkg::STS_FREE_REMOVE;
					end else begin
						occ_clr  = 1'b1;
						r_status = hsa_pkg::STS_OK;
					end
				end
				hsa_pkg::KIND_LOOKUP: begin
					exec_done = 1'b1;
					if (!in_range) begin
						r_status = hsa_pkg::STS_BAD_INDEX;
					end else if (!occ_q[idx_addr]) begin
						r_status = hsa_pkg::STS_EMPTY;
					end else if (rd_q != check_id_q) begin
						r_status = hsa_pkg::STS_MISMATCH;
						r_id     = rd_q;
					end else begin
						r_status = hsa_pkg::STS_OK;
						r_id     = rd_q;
					end
				end
				default: begin
					exec_done = 1'b1;
					r_status  = hsa_pkg::STS_BAD_INDEX;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hsa_pkg::ST_IDLE;
			start_id_q   <= 16'd0;
			id_counter_q <= 16'd0;
			occ_q        <= '0;
			count_q      <= '0;
			max_slot_q   <= '0;
			grp_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				grp_q <= '0;
				if (kind == hsa_pkg::KIND_INSERT) begin
					id_counter_q <= id_adv;
				end
			end
			if (grp_inc) begin
				grp_q <= grp_q + GW'(1);
			end
			if (occ_set) begin
				occ_q[ins_slot] <= 1'b1;
				count_q         <= count_q + CW'(1);
				if (ins_slot > max_slot_q) begin
					max_slot_q <= ins_slot;
				end
			end
			if (occ_clr) begin
				occ_q[idx_addr] <= 1'b0;
				count_q         <= count_q - CW'(1);
			end
			if (cfg_wr) begin
				start_id_q   <= pwdata[15:0];
				id_counter_q <= pwdata[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q       <= kind;
			slot_index_q <= slot_index;
			check_id_q   <= check_id;
		end
		if (exec_done) begin
			status_q      <= r_status;
			result_slot_q <= r_slot;
			result_id_q   <= r_id;
		end
	end

	// id store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_id_q[ins_slot] <= id_counter_q;
		end
		if (state_q == hsa_pkg::ST_IDLE) begin
			rd_q <= slot_id_q[rd_addr];
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(SLOTS))
		else $error("live count above slot count");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == hsa_pkg::ST_EXEC))
		else $error("accepted word did not enter exec");

	a_grp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hsa_pkg::ST_EXEC) |-> (32'(grp_q) < 32'(NGRP)))
		else $error("scan group beyond table");

	a_insert_sets: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> occ_q[$past(ins_slot)])
		else $error("inserted slot not marked occupied");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) &&
		$stable(result_slot) && $stable(result_id) && $stable(live_count)))
		else $error("stalled result word changed");
`endif

endmodule
